// ===== hw/rtl/tsips_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tsips_pkg;

  // Commands on the input channel.
  localparam logic [2:0] CMD_ENABLE    = 3'd0;
  localparam logic [2:0] CMD_DISABLE   = 3'd1;
  localparam logic [2:0] CMD_TRY_STEP  = 3'd2;
  localparam logic [2:0] CMD_BUS_DONE  = 3'd3;
  localparam logic [2:0] CMD_INTERRUPT = 3'd4;

  // Result actions.
  localparam logic [2:0] ACT_NONE       = 3'd0;
  localparam logic [2:0] ACT_WRITE_BYTE = 3'd1;
  localparam logic [2:0] ACT_WRITE_WORD = 3'd2;
  localparam logic [2:0] ACT_READ_BYTE  = 3'd3;
  localparam logic [2:0] ACT_BUTTONS    = 3'd4;
  localparam logic [2:0] ACT_ERROR      = 3'd5;
  localparam logic [2:0] ACT_RESET      = 3'd6;

  // Error kinds.
  localparam logic [1:0] ERR_WRITE    = 2'd0;
  localparam logic [1:0] ERR_READ     = 2'd1;
  localparam logic [1:0] ERR_DEVICE   = 2'd2;
  localparam logic [1:0] ERR_BAD_MODE = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_GAIN      = 3'd0;
  localparam logic [2:0] CFG_THRESHOLD = 3'd1;
  localparam logic [2:0] CFG_AVERAGE   = 3'd2;
  localparam logic [2:0] CFG_FILTER    = 3'd3;
  localparam logic [2:0] CFG_DEBOUNCE  = 3'd4;
  localparam logic [2:0] CFG_SHORT     = 3'd5;
  localparam logic [2:0] CFG_LONG      = 3'd6;
  localparam logic [2:0] CFG_CDAC      = 3'd7;

  // Sensor register addresses.
  localparam logic [7:0] REG_CTRL1  = 8'h1C;
  localparam logic [7:0] REG_CTRL2  = 8'h40;
  localparam logic [7:0] REG_FLAGS  = 8'h1A;
  localparam logic [7:0] REG_BUTTON = 8'h19;

  localparam logic [7:0] BUSY_MASK  = 8'h86;
  localparam logic [7:0] FATAL_MASK = 8'h81;

  // Advance handshake bits.
  localparam logic [3:0] ADV_WAIT_BUS = 4'b0001;
  localparam logic [3:0] ADV_WAIT_INT = 4'b0010;
  localparam logic [3:0] ADV_GOT_BUS  = 4'b0100;
  localparam logic [3:0] ADV_GOT_INT  = 4'b1000;

  // Sequencer modes.
  localparam logic [4:0] MODE_HALT        = 5'd0;
  localparam logic [4:0] MODE_INIT        = 5'd1;
  localparam logic [4:0] MODE_READ_READY  = 5'd2;
  localparam logic [4:0] MODE_CHECK_READY = 5'd3;
  localparam logic [4:0] MODE_WR_RESET    = 5'd4;
  localparam logic [4:0] MODE_WR_GAIN     = 5'd5;
  localparam logic [4:0] MODE_WR_THRESH   = 5'd6;
  localparam logic [4:0] MODE_WR_AVERAGE  = 5'd7;
  localparam logic [4:0] MODE_WR_FILTER   = 5'd8;
  localparam logic [4:0] MODE_WR_DEBOUNCE = 5'd9;
  localparam logic [4:0] MODE_WR_SHORT    = 5'd10;
  localparam logic [4:0] MODE_WR_LONG     = 5'd11;
  localparam logic [4:0] MODE_WR_22       = 5'd12;
  localparam logic [4:0] MODE_WR_23       = 5'd13;
  localparam logic [4:0] MODE_WR_24       = 5'd14;
  localparam logic [4:0] MODE_WR_25       = 5'd15;
  localparam logic [4:0] MODE_WR_26       = 5'd16;
  localparam logic [4:0] MODE_WR_CDAC     = 5'd17;
  localparam logic [4:0] MODE_WR_3E       = 5'd18;
  localparam logic [4:0] MODE_APPLY       = 5'd19;
  localparam logic [4:0] MODE_WAIT_WAKE   = 5'd20;
  localparam logic [4:0] MODE_POLL_TOP    = 5'd21;
  localparam logic [4:0] MODE_READ_FLAGS  = 5'd22;
  localparam logic [4:0] MODE_CHECK_FLAGS = 5'd23;
  localparam logic [4:0] MODE_READ_BUTTON = 5'd24;
  localparam logic [4:0] MODE_REPORT_KEYS = 5'd25;
  localparam logic [4:0] MODE_LOOP_END    = 5'd26;

  typedef struct packed {
    logic [2:0] command;
    logic       bus_ok;
    logic [7:0] bus_status;
    logic [7:0] read_data;
  } in_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] reg_addr;
    logic [7:0] write_value;
    logic [7:0] new_buttons;
    logic [7:0] old_buttons;
    logic [1:0] error_kind;
    logic [7:0] error_detail;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [7:0] gain_value;
    logic [7:0] threshold_value;
    logic [7:0] average_count;
    logic [7:0] filter_value;
    logic [7:0] debounce_count;
    logic [7:0] short_interval;
    logic [7:0] long_interval;
    logic [7:0] cdac_base;
  } cfg_t;

  typedef struct packed {
    logic [4:0] seq_mode;
    logic [3:0] advance_bits;
    logic [7:0] button_bits;
    logic [7:0] last_read_byte;
  } state_t;

  typedef struct packed {
    state_t     state;
    res_t       res0;
    res_t       res1;
    logic [1:0] count;
  } step_out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tsips_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tsips_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tsips_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tsips_step (
  input  var tsips_pkg::in_t       item,
  input  var tsips_pkg::state_t    state,
  input  var tsips_pkg::cfg_t      cfg,
  output tsips_pkg::step_out_t     step
);

  function automatic tsips_pkg::res_t mk_bus(input logic [2:0] action,
                                            input logic [7:0] addr,
                                            input logic [7:0] value);
    tsips_pkg::res_t r;
    r             = '0;
    r.action      = action;
    r.reg_addr    = addr;
    r.write_value = value;
    return r;
  endfunction

  function automatic tsips_pkg::res_t mk_err(input logic [1:0] kind,
                                            input logic [7:0] detail);
    tsips_pkg::res_t r;
    r              = '0;
    r.action       = tsips_pkg::ACT_ERROR;
    r.error_kind   = kind;
    r.error_detail = detail;
    return r;
  endfunction

  logic [1:0] got;
  logic [1:0] waits;
  logic       may_advance;
  logic       is_read;
  logic       jump;
  logic [3:0] adv_n;
  logic [4:0] mode_n;
  logic [7:0] btn_n;
  logic [7:0] lrb_n;
  tsips_pkg::res_t r0;
  tsips_pkg::res_t r1;
  logic [1:0] n;

  assign got   = state.advance_bits[3:2];
  assign waits = state.advance_bits[1:0];

  always_comb begin
    if (got == 2'b00) begin
      may_advance = 1'b0;
    end else if (waits == 2'b11) begin
      may_advance = (got == 2'b11);
    end else begin
      may_advance = (waits[0] && got[0]) || (waits[1] && got[1]);
    end
  end

  assign is_read = (state.seq_mode == tsips_pkg::MODE_CHECK_READY) ||
                   (state.seq_mode == tsips_pkg::MODE_CHECK_FLAGS) ||
                   (state.seq_mode == tsips_pkg::MODE_REPORT_KEYS);

  always_comb begin
    adv_n  = state.advance_bits;
    mode_n = state.seq_mode;
    btn_n  = state.button_bits;
    lrb_n  = state.last_read_byte;
    r0     = '0;
    r1     = '0;
    n      = 2'd0;
    jump   = 1'b0;

    case (item.command)
      tsips_pkg::CMD_ENABLE: begin
        btn_n     = '0;
        r0.action = tsips_pkg::ACT_RESET;
        n         = 2'd1;
        mode_n    = tsips_pkg::MODE_INIT;
        adv_n     = tsips_pkg::ADV_WAIT_INT;
      end
      tsips_pkg::CMD_DISABLE: begin
        mode_n = tsips_pkg::MODE_HALT;
      end
      tsips_pkg::CMD_TRY_STEP: begin
        if (state.seq_mode != tsips_pkg::MODE_HALT && may_advance) begin
          adv_n = tsips_pkg::ADV_WAIT_BUS;
          unique case (state.seq_mode)
            tsips_pkg::MODE_INIT: begin
              r0 = mk_bus(tsips_pkg::ACT_WRITE_BYTE, tsips_pkg::REG_CTRL1, 8'h88);
              n  = 2'd1;
            end
            tsips_pkg::MODE_READ_READY: begin
              r0 = mk_bus(tsips_pkg::ACT_READ_BYTE, tsips_pkg::REG_CTRL1, 8'h00);
              n  = 2'd1;
            end
            tsips_pkg::MODE_CHECK_READY: begin
              if ((state.last_read_byte & tsips_pkg::BUSY_MASK) != 8'h00) begin
                mode_n = tsips_pkg::MODE_INIT;
              end
              jump = 1'b1;
            end
            tsips_pkg::MODE_WR_RESET: begin
              r0 = mk_bus(tsips_pkg::ACT_WRITE_BYTE, 8'h00, 8'hFF);
              n  = 2'd1;
            end
            tsips_pkg::MODE_WR_GAIN: begin
              r0 = mk_bus(tsips_pkg::ACT_WRITE_WORD, 8'h01, cfg.gain_value);
              n  = 2'd1;
            end
            tsips_pkg::MODE_WR_THRESH: begin
              r0 = mk_bus(tsips_pkg::ACT_WRITE_WORD, 8'h09, cfg.threshold_value);
              n  = 2'd1;
            end
            tsips_pkg::MODE_WR_AVERAGE: begin
              r0 = mk_bus(tsips_pkg::ACT_WRITE_BYTE, 8'h1D, cfg.average_count);
              n  = 2'd1;
            end
            tsips_pkg::MODE_WR_FILTER: begin
              r0 = mk_bus(tsips_pkg::ACT_WRITE_BYTE, 8'h1E, cfg.filter_value);
              n  = 2'd1;
            end
            tsips_pkg::MODE_WR_DEBOUNCE: begin
              r0 = mk_bus(tsips_pkg::ACT_WRITE_BYTE, 8'h1F, cfg.debounce_count);
              n  = 2'd1;
            end
            tsips_pkg::MODE_WR_SHORT: begin
              r0 = mk_bus(tsips_pkg::ACT_WRITE_BYTE, 8'h20, cfg.short_interval);
              n  = 2'd1;
            end
            tsips_pkg::MODE_WR_LONG: begin
              r0 = mk_bus(tsips_pkg::ACT_WRITE_BYTE, 8'h21, cfg.long_interval);
              n  = 2'd1;
            end
            tsips_pkg::MODE_WR_22: begin
              r0 = mk_bus(tsips_pkg::ACT_WRITE_BYTE, 8'h22, 8'h04);
              n  = 2'd1;
            end
            tsips_pkg::MODE_WR_23: begin
              r0 = mk_bus(tsips_pkg::ACT_WRITE_BYTE, 8'h23, 8'h03);
              n  = 2'd1;
            end
            tsips_pkg::MODE_WR_24: begin
              r0 = mk_bus(tsips_pkg::ACT_WRITE_BYTE, 8'h24, 8'h03);
              n  = 2'd1;
            end
            tsips_pkg::MODE_WR_25: begin
              r0 = mk_bus(tsips_pkg::ACT_WRITE_BYTE, 8'h25, 8'h32);
              n  = 2'd1;
            end
            tsips_pkg::MODE_WR_26: begin
              r0 = mk_bus(tsips_pkg::ACT_WRITE_BYTE, 8'h26, 8'h01);
              n  = 2'd1;
            end
            tsips_pkg::MODE_WR_CDAC: begin
              r0 = mk_bus(tsips_pkg::ACT_WRITE_BYTE, 8'h3D, cfg.cdac_base);
              n  = 2'd1;
            end
            tsips_pkg::MODE_WR_3E: begin
              r0 = mk_bus(tsips_pkg::ACT_WRITE_BYTE, 8'h3E, 8'h00);
              n  = 2'd1;
            end
            tsips_pkg::MODE_APPLY: begin
              r0 = mk_bus(tsips_pkg::ACT_WRITE_BYTE, tsips_pkg::REG_CTRL1, 8'h8F);
              n  = 2'd1;
            end
            tsips_pkg::MODE_WAIT_WAKE: begin
              adv_n = tsips_pkg::ADV_WAIT_INT;
            end
            tsips_pkg::MODE_POLL_TOP: begin
              jump = 1'b1;
            end
            tsips_pkg::MODE_READ_FLAGS: begin
              r0 = mk_bus(tsips_pkg::ACT_READ_BYTE, tsips_pkg::REG_FLAGS, 8'h00);
              n  = 2'd1;
            end
            tsips_pkg::MODE_CHECK_FLAGS: begin
              if ((state.last_read_byte & tsips_pkg::FATAL_MASK) != 8'h00) begin
                r0     = mk_err(tsips_pkg::ERR_DEVICE, state.last_read_byte);
                n      = 2'd1;
                mode_n = tsips_pkg::MODE_HALT;
              end
              jump = 1'b1;
            end
            tsips_pkg::MODE_READ_BUTTON: begin
              r0 = mk_bus(tsips_pkg::ACT_READ_BYTE, tsips_pkg::REG_BUTTON, 8'h00);
              n  = 2'd1;
            end
            tsips_pkg::MODE_REPORT_KEYS: begin
              if (state.last_read_byte != state.button_bits) begin
                r0             = '0;
                r0.action      = tsips_pkg::ACT_BUTTONS;
                r0.new_buttons = state.last_read_byte;
                r0.old_buttons = state.button_bits;
                r1             = mk_bus(tsips_pkg::ACT_WRITE_BYTE, tsips_pkg::REG_CTRL2,
                                        8'h00);
                btn_n          = state.last_read_byte;
                n              = 2'd2;
              end else begin
                r0 = mk_bus(tsips_pkg::ACT_WRITE_BYTE, tsips_pkg::REG_CTRL2, 8'h00);
                n  = 2'd1;
              end
            end
            tsips_pkg::MODE_LOOP_END: begin
              adv_n = tsips_pkg::ADV_WAIT_INT;
            end
            default: begin
              r0     = mk_err(tsips_pkg::ERR_BAD_MODE, {3'b000, state.seq_mode});
              n      = 2'd1;
              mode_n = tsips_pkg::MODE_HALT;
              jump   = 1'b1;
            end
          endcase

          if (mode_n != tsips_pkg::MODE_HALT) begin
            if (mode_n < tsips_pkg::MODE_LOOP_END) begin
              mode_n = mode_n + 5'd1;
            end else begin
              mode_n = tsips_pkg::MODE_POLL_TOP;
            end
          end
          // The happened bits were just cleared, so the event always lands.
          if (jump) begin
            adv_n = adv_n | tsips_pkg::ADV_GOT_BUS;
          end
        end
      end
      tsips_pkg::CMD_BUS_DONE: begin
        if (!item.bus_ok) begin
          r0     = mk_err(is_read ? tsips_pkg::ERR_READ : tsips_pkg::ERR_WRITE,
                          item.bus_status);
          n      = 2'd1;
          mode_n = tsips_pkg::MODE_HALT;
        end else begin
          if (is_read) begin
            lrb_n = item.read_data;
          end
          if (got == 2'b00) begin
            adv_n = state.advance_bits | tsips_pkg::ADV_GOT_BUS;
          end
        end
      end
      tsips_pkg::CMD_INTERRUPT: begin
        if (got == 2'b00) begin
          adv_n = state.advance_bits | tsips_pkg::ADV_GOT_INT;
        end
      end
      default: begin
      end
    endcase

    r0.last = (n == 2'd1);
    r1.last = 1'b1;
  end

  assign step.state.seq_mode       = mode_n;
  assign step.state.advance_bits   = adv_n;
  assign step.state.button_bits    = btn_n;
  assign step.state.last_read_byte = lrb_n;
  assign step.res0                 = r0;
  assign step.res1                 = r1;
  assign step.count                = n;

endmodule

`default_nettype wire

// ===== hw/rtl/touch_sensor_init_poll_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Init and poll sequencer for a capacitive touch controller on a two-wire bus.
// The input channel carries events: enable, disable, try step, bus transfer
// done and sensor interrupt. Each accepted beat is decided in the cycle it is
// accepted and gives zero, one or two result beats on the output channel
// (bus requests, button changes, error reports, reset pulse); the final
// result beat of an event carries last.
// An event's first result beat shows on the output channel in the cycle after
// the event was accepted. One event per cycle is accepted while every event
// yields at most one beat and the receiver keeps ready high; an event with
// two result beats holds the input until its second is taken. A two-entry
// output queue separates the channels. Input ready is high when the queue is
// empty, or holds one beat that is being taken in the same cycle. When the
// receiver stalls, the queued beats hold and the input stalls too. The
// configuration registers are written through cfg_we, cfg_index and cfg_wdata
// and take effect on the next step; the user must write them only while idle,
// which the block does not enforce. Reset halts the sequencer, clears all
// handshake bits, loads configuration defaults and empties the output queue.
module touch_sensor_init_poll_sequencer (
  input  wire logic            clk,
  input  wire logic            rst_n,
  tsips_stream_if.sink         in_chan,
  tsips_stream_if.source       out_chan,
  input  wire logic            cfg_we,
  input  wire logic [2:0]      cfg_index,
  input  wire logic [7:0]      cfg_wdata
);

  tsips_pkg::cfg_t      cfg_r;
  tsips_pkg::cfg_t      cfg_nxt;
  tsips_pkg::state_t    state_r;
  tsips_pkg::state_t    state_nxt;
  tsips_pkg::res_t      q0_r;
  tsips_pkg::res_t      q0_nxt;
  tsips_pkg::res_t      q1_r;
  tsips_pkg::res_t      q1_nxt;
  logic [1:0]           count_r;
  logic [1:0]           count_nxt;
  tsips_pkg::step_out_t step;
  tsips_pkg::in_t       item;
  logic                 pop;
  logic                 acc;

  assign item = in_chan.data;

  tsips_step u_step (
    .item  (item),
    .state (state_r),
    .cfg   (cfg_r),
    .step  (step)
  );

  assign pop            = (count_r != 2'd0) && out_chan.ready;
  assign in_chan.ready  = (count_r == 2'd0) || ((count_r == 2'd1) && out_chan.ready);
  assign acc            = in_chan.valid && in_chan.ready;
  assign out_chan.valid = (count_r != 2'd0);
  assign out_chan.data  = q0_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        tsips_pkg::CFG_GAIN:      cfg_nxt.gain_value      = cfg_wdata;
        tsips_pkg::CFG_THRESHOLD: cfg_nxt.threshold_value = cfg_wdata;
        tsips_pkg::CFG_AVERAGE:   cfg_nxt.average_count   = cfg_wdata;
        tsips_pkg::CFG_FILTER:    cfg_nxt.filter_value    = cfg_wdata;
        tsips_pkg::CFG_DEBOUNCE:  cfg_nxt.debounce_count  = cfg_wdata;
        tsips_pkg::CFG_SHORT:     cfg_nxt.short_interval  = cfg_wdata;
        tsips_pkg::CFG_LONG:      cfg_nxt.long_interval   = cfg_wdata;
        tsips_pkg::CFG_CDAC:      cfg_nxt.cdac_base       = cfg_wdata;
        default:                  cfg_nxt                 = cfg_r;
      endcase
    end
  end

  always_comb begin
    state_nxt = acc ? step.state : state_r;
    q0_nxt    = q0_r;
    q1_nxt    = q1_r;
    count_nxt = count_r;
    if (pop) begin
      count_nxt = count_r - 2'd1;
      q0_nxt    = q1_r;
    end
    // An accepted beat always finds the queue empty after this cycle's pop.
    if (acc) begin
      count_nxt = step.count;
      q0_nxt    = step.res0;
      q1_nxt    = step.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_value      <= 8'd80;
      cfg_r.threshold_value <= 8'd10;
      cfg_r.average_count   <= 8'd128;
      cfg_r.filter_value    <= 8'd0;
      cfg_r.debounce_count  <= 8'd1;
      cfg_r.short_interval  <= 8'd5;
      cfg_r.long_interval   <= 8'd1;
      cfg_r.cdac_base       <= 8'd128;
      state_r.seq_mode       <= tsips_pkg::MODE_HALT;
      state_r.advance_bits   <= '0;
      state_r.button_bits    <= '0;
      state_r.last_read_byte <= '0;
      count_r <= 2'd0;
    end else begin
      cfg_r   <= cfg_nxt;
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("Output queue holds more than two beats.");

  a_head_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == 2'd2 |-> !q0_r.last && q1_r.last)
    else $error("Only the second of two queued beats may carry last.");

  a_single_event: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(state_r.advance_bits[3:2]) <= 1)
    else $error("Both happened bits are set at once.");

  a_enable_mode: assert property (@(posedge clk) disable iff (!rst_n)
    acc && item.command == tsips_pkg::CMD_ENABLE |=>
      state_r.seq_mode == tsips_pkg::MODE_INIT && count_r == 2'd1 &&
      q0_r.action == tsips_pkg::ACT_RESET)
    else $error("Enable did not restart the sequence with a reset pulse.");

  a_disable_mode: assert property (@(posedge clk) disable iff (!rst_n)
    acc && item.command == tsips_pkg::CMD_DISABLE |=>
      state_r.seq_mode == tsips_pkg::MODE_HALT && count_r == 2'd0)
    else $error("Disable did not park the sequencer silently.");

endmodule

`default_nettype wire

// ===== sim/touch_sensor_init_poll_sequencer_tb.sv =====
`timescale 1ns / 1ps

module touch_sensor_init_poll_sequencer_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;
  localparam int PHASES = 5;
  localparam int PHASE_ITEMS = 130;
  localparam int PREDICT = -1;

  localparam logic [2:0] CMD_RESERVED = 3'd7;
  localparam logic [7:0] CTRL1_INIT = 8'h88;
  localparam logic [7:0] CTRL1_APPLY = 8'h8F;
  localparam logic [3:0] ADV_GOT_ANY = tsips_pkg::ADV_GOT_BUS | tsips_pkg::ADV_GOT_INT;
  localparam logic [3:0] ADV_WAIT_ANY = tsips_pkg::ADV_WAIT_BUS | tsips_pkg::ADV_WAIT_INT;

  typedef struct {
    tsips_pkg::in_t  ev;
    int              typed;
    tsips_pkg::res_t want;
  } row_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [7:0] cfg_wdata;

  tsips_stream_if #(.payload_t(tsips_pkg::in_t)) in_if ();
  tsips_stream_if #(.payload_t(tsips_pkg::res_t)) out_if ();

  touch_sensor_init_poll_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  tsips_pkg::cfg_t pred_cfg;
  logic [4:0]      pred_mode;
  logic [3:0]      pred_adv;
  logic [7:0]      pred_buttons;
  logic [7:0]      pred_rd_byte;
  tsips_pkg::res_t produced[$];
  tsips_pkg::res_t awaited_beats[$];
  int              errors;
  bit              idling_on;
  bit              long_hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic tsips_pkg::res_t bus_beat(logic [2:0] action, logic [7:0] addr,
                                               logic [7:0] value);
    tsips_pkg::res_t r;
    r = '0;
    r.action = action;
    r.reg_addr = addr;
    r.write_value = value;
    return r;
  endfunction

  function automatic tsips_pkg::res_t err_beat(logic [1:0] kind, logic [7:0] detail);
    tsips_pkg::res_t r;
    r = '0;
    r.action = tsips_pkg::ACT_ERROR;
    r.error_kind = kind;
    r.error_detail = detail;
    return r;
  endfunction

  function automatic bit can_advance();
    if ((pred_adv & ADV_GOT_ANY) == 4'b0000) return 1'b0;
    if ((pred_adv & ADV_WAIT_ANY) == ADV_WAIT_ANY) return (pred_adv & ADV_GOT_ANY) == ADV_GOT_ANY;
    if ((pred_adv & tsips_pkg::ADV_WAIT_BUS) != 4'b0000 &&
        (pred_adv & tsips_pkg::ADV_GOT_BUS) != 4'b0000) return 1'b1;
    if ((pred_adv & tsips_pkg::ADV_WAIT_INT) != 4'b0000 &&
        (pred_adv & tsips_pkg::ADV_GOT_INT) != 4'b0000) return 1'b1;
    return 1'b0;
  endfunction

  // A happened event masks any further one until the next step or enable.
  function automatic void note_happening(logic [3:0] got_bit);
    if ((pred_adv & ADV_GOT_ANY) == 4'b0000) pred_adv = pred_adv | got_bit;
  endfunction

  task automatic try_advance();
    logic [4:0]      m;
    bit              jump;
    tsips_pkg::res_t r;
    m = pred_mode;
    jump = 1'b0;
    if (m == tsips_pkg::MODE_HALT || !can_advance()) return;
    pred_adv = tsips_pkg::ADV_WAIT_BUS;
    case (m)
      tsips_pkg::MODE_INIT:
        produced.push_back(bus_beat(tsips_pkg::ACT_WRITE_BYTE, tsips_pkg::REG_CTRL1,
                                    CTRL1_INIT));
      tsips_pkg::MODE_READ_READY:
        produced.push_back(bus_beat(tsips_pkg::ACT_READ_BYTE, tsips_pkg::REG_CTRL1, 8'h00));
      tsips_pkg::MODE_CHECK_READY: begin
        if ((pred_rd_byte & tsips_pkg::BUSY_MASK) != 8'h00) pred_mode = tsips_pkg::MODE_INIT;
        jump = 1'b1;
      end
      tsips_pkg::MODE_WR_RESET:
        produced.push_back(bus_beat(tsips_pkg::ACT_WRITE_BYTE, 8'h00, 8'hFF));
      tsips_pkg::MODE_WR_GAIN:
        produced.push_back(bus_beat(tsips_pkg::ACT_WRITE_WORD, 8'h01, pred_cfg.gain_value));
      tsips_pkg::MODE_WR_THRESH:
        produced.push_back(bus_beat(tsips_pkg::ACT_WRITE_WORD, 8'h09,
                                    pred_cfg.threshold_value));
      tsips_pkg::MODE_WR_AVERAGE:
        produced.push_back(bus_beat(tsips_pkg::ACT_WRITE_BYTE, 8'h1D,
                                    pred_cfg.average_count));
      tsips_pkg::MODE_WR_FILTER:
        produced.push_back(bus_beat(tsips_pkg::ACT_WRITE_BYTE, 8'h1E, pred_cfg.filter_value));
      tsips_pkg::MODE_WR_DEBOUNCE:
        produced.push_back(bus_beat(tsips_pkg::ACT_WRITE_BYTE, 8'h1F,
                                    pred_cfg.debounce_count));
      tsips_pkg::MODE_WR_SHORT:
        produced.push_back(bus_beat(tsips_pkg::ACT_WRITE_BYTE, 8'h20,
                                    pred_cfg.short_interval));
      tsips_pkg::MODE_WR_LONG:
        produced.push_back(bus_beat(tsips_pkg::ACT_WRITE_BYTE, 8'h21,
                                    pred_cfg.long_interval));
      tsips_pkg::MODE_WR_22:
        produced.push_back(bus_beat(tsips_pkg::ACT_WRITE_BYTE, 8'h22, 8'h04));
      tsips_pkg::MODE_WR_23:
        produced.push_back(bus_beat(tsips_pkg::ACT_WRITE_BYTE, 8'h23, 8'h03));
      tsips_pkg::MODE_WR_24:
        produced.push_back(bus_beat(tsips_pkg::ACT_WRITE_BYTE, 8'h24, 8'h03));
      tsips_pkg::MODE_WR_25:
        produced.push_back(bus_beat(tsips_pkg::ACT_WRITE_BYTE, 8'h25, 8'h32));
      tsips_pkg::MODE_WR_26:
        produced.push_back(bus_beat(tsips_pkg::ACT_WRITE_BYTE, 8'h26, 8'h01));
      tsips_pkg::MODE_WR_CDAC:
        produced.push_back(bus_beat(tsips_pkg::ACT_WRITE_BYTE, 8'h3D, pred_cfg.cdac_base));
      tsips_pkg::MODE_WR_3E:
        produced.push_back(bus_beat(tsips_pkg::ACT_WRITE_BYTE, 8'h3E, 8'h00));
      tsips_pkg::MODE_APPLY:
        produced.push_back(bus_beat(tsips_pkg::ACT_WRITE_BYTE, tsips_pkg::REG_CTRL1,
                                    CTRL1_APPLY));
      tsips_pkg::MODE_WAIT_WAKE: pred_adv = tsips_pkg::ADV_WAIT_INT;
      tsips_pkg::MODE_POLL_TOP: jump = 1'b1;
      tsips_pkg::MODE_READ_FLAGS:
        produced.push_back(bus_beat(tsips_pkg::ACT_READ_BYTE, tsips_pkg::REG_FLAGS, 8'h00));
      tsips_pkg::MODE_CHECK_FLAGS: begin
        if ((pred_rd_byte & tsips_pkg::FATAL_MASK) != 8'h00) begin
          produced.push_back(err_beat(tsips_pkg::ERR_DEVICE, pred_rd_byte));
          pred_mode = tsips_pkg::MODE_HALT;
        end
        jump = 1'b1;
      end
      tsips_pkg::MODE_READ_BUTTON:
        produced.push_back(bus_beat(tsips_pkg::ACT_READ_BYTE, tsips_pkg::REG_BUTTON, 8'h00));
      tsips_pkg::MODE_REPORT_KEYS: begin
        if (pred_rd_byte != pred_buttons) begin
          r = '0;
          r.action = tsips_pkg::ACT_BUTTONS;
          r.new_buttons = pred_rd_byte;
          r.old_buttons = pred_buttons;
          produced.push_back(r);
          pred_buttons = pred_rd_byte;
        end
        produced.push_back(bus_beat(tsips_pkg::ACT_WRITE_BYTE, tsips_pkg::REG_CTRL2, 8'h00));
      end
      tsips_pkg::MODE_LOOP_END: pred_adv = tsips_pkg::ADV_WAIT_INT;
      default: begin
        produced.push_back(err_beat(tsips_pkg::ERR_BAD_MODE, {3'b000, m}));
        pred_mode = tsips_pkg::MODE_HALT;
        jump = 1'b1;
      end
    endcase
    if (pred_mode != tsips_pkg::MODE_HALT) begin
      pred_mode = (pred_mode < tsips_pkg::MODE_LOOP_END) ? pred_mode + 5'd1 :
                  tsips_pkg::MODE_POLL_TOP;
    end
    if (jump) note_happening(tsips_pkg::ADV_GOT_BUS);
  endtask

  task automatic sequence_event(tsips_pkg::in_t ev);
    bit is_read;
    produced.delete();
    case (ev.command)
      tsips_pkg::CMD_ENABLE: begin
        pred_buttons = 8'h00;
        produced.push_back(bus_beat(tsips_pkg::ACT_RESET, 8'h00, 8'h00));
        pred_mode = tsips_pkg::MODE_INIT;
        pred_adv = tsips_pkg::ADV_WAIT_INT;
      end
      tsips_pkg::CMD_DISABLE: pred_mode = tsips_pkg::MODE_HALT;
      tsips_pkg::CMD_TRY_STEP: try_advance();
      tsips_pkg::CMD_BUS_DONE: begin
        is_read = pred_mode == tsips_pkg::MODE_CHECK_READY ||
                  pred_mode == tsips_pkg::MODE_CHECK_FLAGS ||
                  pred_mode == tsips_pkg::MODE_REPORT_KEYS;
        if (!ev.bus_ok) begin
          produced.push_back(err_beat(is_read ? tsips_pkg::ERR_READ : tsips_pkg::ERR_WRITE,
                                      ev.bus_status));
          pred_mode = tsips_pkg::MODE_HALT;
        end else begin
          if (is_read) pred_rd_byte = ev.read_data;
          note_happening(tsips_pkg::ADV_GOT_BUS);
        end
      end
      tsips_pkg::CMD_INTERRUPT: note_happening(tsips_pkg::ADV_GOT_INT);
      default: ;
    endcase
    if (produced.size() != 0) produced[produced.size() - 1].last = 1'b1;
  endtask

  // Mostly the event the sequencer is waiting for, with a little noise mixed in.
  function automatic tsips_pkg::in_t next_event();
    tsips_pkg::in_t ev;
    int             roll;
    roll = $urandom_range(0, 99);
    ev.command = tsips_pkg::CMD_TRY_STEP;
    ev.bus_ok = 1'b1;
    ev.bus_status = 8'($urandom_range(0, 255));
    ev.read_data = 8'($urandom_range(0, 255));
    if (roll < 8) begin
      ev.command = 3'($urandom_range(0, 7));
      ev.bus_ok = 1'($urandom_range(0, 1));
    end else if (pred_mode == tsips_pkg::MODE_HALT) begin
      ev.command = tsips_pkg::CMD_ENABLE;
    end else if (can_advance()) begin
      ev.command = tsips_pkg::CMD_TRY_STEP;
    end else if ((pred_adv & ADV_GOT_ANY) != 4'b0000) begin
      ev.command = tsips_pkg::CMD_ENABLE;
    end else if ((pred_adv & tsips_pkg::ADV_WAIT_BUS) != 4'b0000) begin
      ev.command = tsips_pkg::CMD_BUS_DONE;
      ev.bus_ok = roll >= 11;
      if (pred_mode == tsips_pkg::MODE_CHECK_READY && roll < 75) begin
        ev.read_data = ev.read_data & ~tsips_pkg::BUSY_MASK;
      end else if (pred_mode == tsips_pkg::MODE_CHECK_FLAGS && roll < 90) begin
        ev.read_data = ev.read_data & ~tsips_pkg::FATAL_MASK;
      end else if (pred_mode == tsips_pkg::MODE_REPORT_KEYS && roll < 50) begin
        ev.read_data = pred_buttons;
      end
    end else begin
      ev.command = tsips_pkg::CMD_INTERRUPT;
    end
    return ev;
  endfunction

  function automatic row_t mk_row(logic [2:0] cmd, logic ok, logic [7:0] status,
                                  logic [7:0] data, int typed, tsips_pkg::res_t want);
    row_t row;
    row.ev.command = cmd;
    row.ev.bus_ok = ok;
    row.ev.bus_status = status;
    row.ev.read_data = data;
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 50) $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
  endtask

  task automatic send_event(tsips_pkg::in_t ev);
    @(negedge clk);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= ev;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    sequence_event(ev);
  endtask

  task automatic write_register(logic [2:0] idx, logic [7:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
  endtask

  task automatic load_settings(tsips_pkg::cfg_t s);
    write_register(tsips_pkg::CFG_GAIN, s.gain_value);
    write_register(tsips_pkg::CFG_THRESHOLD, s.threshold_value);
    write_register(tsips_pkg::CFG_AVERAGE, s.average_count);
    write_register(tsips_pkg::CFG_FILTER, s.filter_value);
    write_register(tsips_pkg::CFG_DEBOUNCE, s.debounce_count);
    write_register(tsips_pkg::CFG_SHORT, s.short_interval);
    write_register(tsips_pkg::CFG_LONG, s.long_interval);
    write_register(tsips_pkg::CFG_CDAC, s.cdac_base);
    @(negedge clk);
    cfg_we <= 1'b0;
    pred_cfg = s;
  endtask

  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (awaited_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold_req = 1'b0;
        out_if.ready <= 1'b1;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : take_result
    tsips_pkg::res_t got;
    tsips_pkg::res_t want;
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got = out_if.data;
      if (awaited_beats.size() == 0) begin
        report_mismatch($sformatf("beat with nothing awaited, action %0d", got.action));
      end else begin
        want = awaited_beats.pop_front();
        check_field("action", 8'(got.action), 8'(want.action));
        check_field("reg_addr", got.reg_addr, want.reg_addr);
        check_field("write_value", got.write_value, want.write_value);
        check_field("new_buttons", got.new_buttons, want.new_buttons);
        check_field("old_buttons", got.old_buttons, want.old_buttons);
        check_field("error_kind", 8'(got.error_kind), 8'(want.error_kind));
        check_field("error_detail", got.error_detail, want.error_detail);
        check_field("last", 8'(got.last), 8'(want.last));
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("** touch_sensor_init_poll_sequencer: FAILED **");
    $finish;
  end

  initial begin
    row_t            plan[$];
    tsips_pkg::cfg_t setting;
    tsips_pkg::in_t  ev;
    tsips_pkg::res_t want;
    int              counted;
    int              sent;

    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_we = 1'b0;
    cfg_index = tsips_pkg::CFG_GAIN;
    cfg_wdata = 8'h00;
    errors = 0;
    idling_on = 1'b1;
    long_hold_req = 1'b0;

    pred_cfg.gain_value = 8'd80;
    pred_cfg.threshold_value = 8'd10;
    pred_cfg.average_count = 8'd128;
    pred_cfg.filter_value = 8'd0;
    pred_cfg.debounce_count = 8'd1;
    pred_cfg.short_interval = 8'd5;
    pred_cfg.long_interval = 8'd1;
    pred_cfg.cdac_base = 8'd128;
    pred_mode = tsips_pkg::MODE_HALT;
    pred_adv = 4'b0000;
    pred_buttons = 8'h00;
    pred_rd_byte = 8'h00;

    // Idle after reset with a failed transfer, then a stray event that blocks the
    // interrupt wait, then the ready poll with one retry and a write failure.
    plan.push_back(mk_row(tsips_pkg::CMD_TRY_STEP, 1'b1, 8'h00, 8'h00, 0, '0));
    plan.push_back(mk_row(tsips_pkg::CMD_BUS_DONE, 1'b1, 8'h00, 8'hFF, 0, '0));
    plan.push_back(mk_row(tsips_pkg::CMD_BUS_DONE, 1'b0, 8'hFF, 8'h00, 1,
                          err_beat(tsips_pkg::ERR_WRITE, 8'hFF)));
    plan.push_back(mk_row(CMD_RESERVED, 1'b1, 8'hFF, 8'hFF, 0, '0));
    plan.push_back(mk_row(tsips_pkg::CMD_ENABLE, 1'b0, 8'h00, 8'h00, 1,
                          bus_beat(tsips_pkg::ACT_RESET, 8'h00, 8'h00)));
    plan.push_back(mk_row(tsips_pkg::CMD_TRY_STEP, 1'b1, 8'h00, 8'h00, 0, '0));
    plan.push_back(mk_row(tsips_pkg::CMD_BUS_DONE, 1'b1, 8'h00, 8'h00, 0, '0));
    plan.push_back(mk_row(tsips_pkg::CMD_INTERRUPT, 1'b1, 8'h00, 8'h00, 0, '0));
    plan.push_back(mk_row(tsips_pkg::CMD_TRY_STEP, 1'b1, 8'h00, 8'h00, 0, '0));
    plan.push_back(mk_row(tsips_pkg::CMD_ENABLE, 1'b1, 8'hFF, 8'hFF, 1,
                          bus_beat(tsips_pkg::ACT_RESET, 8'h00, 8'h00)));
    plan.push_back(mk_row(tsips_pkg::CMD_INTERRUPT, 1'b0, 8'h00, 8'h00, 0, '0));
    plan.push_back(mk_row(tsips_pkg::CMD_INTERRUPT, 1'b1, 8'hFF, 8'hFF, 0, '0));
    plan.push_back(mk_row(tsips_pkg::CMD_TRY_STEP, 1'b1, 8'h00, 8'h00, 1,
                          bus_beat(tsips_pkg::ACT_WRITE_BYTE, tsips_pkg::REG_CTRL1,
                                   CTRL1_INIT)));
    plan.push_back(mk_row(tsips_pkg::CMD_BUS_DONE, 1'b1, 8'h00, 8'hFF, 0, '0));
    plan.push_back(mk_row(tsips_pkg::CMD_TRY_STEP, 1'b1, 8'h00, 8'h00, 1,
                          bus_beat(tsips_pkg::ACT_READ_BYTE, tsips_pkg::REG_CTRL1, 8'h00)));
    plan.push_back(mk_row(tsips_pkg::CMD_BUS_DONE, 1'b1, 8'h00, 8'h86, PREDICT, '0));
    plan.push_back(mk_row(tsips_pkg::CMD_TRY_STEP, 1'b1, 8'h00, 8'h00, PREDICT, '0));
    plan.push_back(mk_row(tsips_pkg::CMD_TRY_STEP, 1'b1, 8'h00, 8'h00, PREDICT, '0));
    plan.push_back(mk_row(tsips_pkg::CMD_BUS_DONE, 1'b1, 8'h00, 8'h79, PREDICT, '0));
    plan.push_back(mk_row(tsips_pkg::CMD_TRY_STEP, 1'b1, 8'h00, 8'h00, PREDICT, '0));
    plan.push_back(mk_row(tsips_pkg::CMD_TRY_STEP, 1'b1, 8'h00, 8'h00, PREDICT, '0));
    plan.push_back(mk_row(tsips_pkg::CMD_BUS_DONE, 1'b0, 8'h00, 8'h00, 1,
                          err_beat(tsips_pkg::ERR_WRITE, 8'h00)));
    plan.push_back(mk_row(tsips_pkg::CMD_DISABLE, 1'b1, 8'hFF, 8'hFF, 0, '0));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      send_event(plan[i].ev);
      if (plan[i].typed == PREDICT) begin
        foreach (produced[k]) awaited_beats.push_back(produced[k]);
      end else if (plan[i].typed > 0) begin
        want = plan[i].want;
        want.last = 1'b1;
        awaited_beats.push_back(want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      idling_on = p != PHASES - 1;
      case (p)
        0: setting = '0;
        1: setting = '1;
        default: setting = {$urandom(), $urandom()};
      endcase
      load_settings(setting);
      counted = 0;
      sent = 0;
      while (counted < PHASE_ITEMS) begin
        ev = next_event();
        send_event(ev);
        foreach (produced[k]) awaited_beats.push_back(produced[k]);
        sent++;
        if (ev.command <= tsips_pkg::CMD_INTERRUPT) counted++;
        if (p == 1 && sent == 20) long_hold_req = 1'b1;
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (awaited_beats.size() != 0) begin
      report_mismatch($sformatf("%0d result beats never arrived", awaited_beats.size()));
    end
    if (errors == 0) begin
      $display("** touch_sensor_init_poll_sequencer: PASSED **");
    end else begin
      $display("** touch_sensor_init_poll_sequencer: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/tsips_pkg.sv
hw/rtl/tsips_stream_if.sv
hw/rtl/tsips_step.sv
hw/rtl/touch_sensor_init_poll_sequencer.sv
sim/touch_sensor_init_poll_sequencer_tb.sv
